>>> design/dcam_pkg.sv
// shared types and codes for the dual channel averaging monitor
// no dependencies; imported by the channel engine, reply unit and top level
`timescale 1ns / 1ps

package dcam_pkg;

  // action codes carried on the input tuser
  localparam logic [1:0] ACT_VOLT = 2'd0;
  localparam logic [1:0] ACT_CURR = 2'd1;
  localparam logic [1:0] ACT_CMD  = 2'd2;

  // bus command codes
  localparam logic [7:0] CMD_LED    = 8'h00;
  localparam logic [7:0] CMD_RAW_V  = 8'h01;
  localparam logic [7:0] CMD_RAW_I  = 8'h02;
  localparam logic [7:0] CMD_MEAN_V = 8'h03;
  localparam logic [7:0] CMD_MEAN_I = 8'h04;
  localparam logic [7:0] CMD_DEVID  = 8'h80;

  localparam logic [7:0] DEVICE_ID = 8'h42;

  // led mode data byte
  localparam logic [7:0] LED_OFF  = 8'h00;
  localparam logic [7:0] LED_ON   = 8'h01;
  localparam logic [7:0] LED_CRIT = 8'h02;

  // reply lengths
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_ONE  = 2'd1;
  localparam logic [1:0] LEN_TWO  = 2'd2;

  // width of a value read back over the bus, high byte first
  localparam int REPLY_W = 16;

  typedef struct packed {
    logic [7:0] command;
    logic       has_data;
    logic [7:0] data_byte;
  } cmd_beat_t;

  typedef enum logic [1:0] {
    RD_RAW_V,
    RD_RAW_I,
    RD_MEAN_V,
    RD_MEAN_I
  } rd_sel_t;

endpackage

>>> design/dcam_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module dcam_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/dcam_chan.sv
// sample engine: ring memory, write positions, running sums and last raw values
// depends on dcam_pkg and dcam_ram
`timescale 1ns / 1ps

module dcam_chan #(
  parameter int AVG_DEPTH   = 8,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         smp_valid,
  input  logic                         smp_ch,
  input  logic [SAMPLE_BITS-1:0]       smp_value,
  input  dcam_pkg::rd_sel_t            rd_sel,
  output logic [dcam_pkg::REPLY_W-1:0] rd_value
);
  import dcam_pkg::*;

  localparam int PW    = $clog2(AVG_DEPTH);
  localparam int AW    = PW + 1;
  localparam int SUM_W = SAMPLE_BITS + PW;
  // reciprocal of the depth, exact for every sum below 2**SUM_W
  localparam int SHIFT = SUM_W + PW;
  localparam int PROD_W = SUM_W + SHIFT;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [SHIFT-1:0] RECIP    = SHIFT'(RECIP_FULL);
  localparam logic [PW-1:0]    POS_LAST = PW'(AVG_DEPTH - 1);
  localparam logic [PW-1:0]    POS_ONE  = PW'(1);

  logic [PW-1:0]          pos_r   [2];
  logic [1:0]             primed_r;
  logic [1:0]             done_r;
  logic [SAMPLE_BITS-1:0] first_r [2];
  logic [SAMPLE_BITS-1:0] raw_r   [2];
  logic [SUM_W-1:0]       sum_r   [2];

  logic                   s1_valid_r;
  logic                   s1_prime_r;
  logic                   s1_mem_r;
  logic                   s1_ch_r;
  logic [SAMPLE_BITS-1:0] s1_value_r;
  logic [AW-1:0]          s1_addr_r;

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] ram_q;
  logic [SAMPLE_BITS-1:0] old_value;
  logic [SUM_W-1:0]       sum_nxt;
  logic                   wr_en;

  logic [SUM_W-1:0]       mean_src;
  logic [PROD_W-1:0]      mean_prod;
  logic [SAMPLE_BITS-1:0] mean_value;

  // stage 0: look up the entry that this sample replaces
  assign rd_en   = smp_valid && primed_r[smp_ch];
  assign rd_addr = {smp_ch, pos_r[smp_ch]};

  dcam_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(2 ** AW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s1_addr_r),
    .wr_data(s1_value_r),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r   <= '0;
      done_r     <= '0;
      pos_r[0]   <= '0;
      pos_r[1]   <= '0;
      raw_r[0]   <= '0;
      raw_r[1]   <= '0;
      sum_r[0]   <= '0;
      sum_r[1]   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= smp_valid;
      if (smp_valid) begin
        raw_r[smp_ch] <= smp_value;
        if (!primed_r[smp_ch]) begin
          primed_r[smp_ch] <= 1'b1;
          pos_r[smp_ch]    <= POS_ONE;
        end else begin
          pos_r[smp_ch] <= (pos_r[smp_ch] == POS_LAST) ? '0 : pos_r[smp_ch] + POS_ONE;
          // entry zero is the last one still holding the priming value
          if (pos_r[smp_ch] == '0) begin
            done_r[smp_ch] <= 1'b1;
          end
        end
      end
      if (s1_valid_r) begin
        sum_r[s1_ch_r] <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid) begin
      s1_ch_r    <= smp_ch;
      s1_value_r <= smp_value;
      s1_prime_r <= !primed_r[smp_ch];
      s1_mem_r   <= done_r[smp_ch];
      s1_addr_r  <= rd_addr;
      if (!primed_r[smp_ch]) begin
        first_r[smp_ch] <= smp_value;
      end
    end
  end

  // stage 1: running sum update and ring write back
  assign old_value = s1_mem_r ? ram_q : first_r[s1_ch_r];
  assign wr_en     = s1_valid_r && !s1_prime_r;

  always_comb begin
    if (s1_prime_r) begin
      sum_nxt = SUM_W'(SUM_W'(s1_value_r) * SUM_W'(AVG_DEPTH));
    end else begin
      sum_nxt = sum_r[s1_ch_r] - SUM_W'(old_value) + SUM_W'(s1_value_r);
    end
  end

  // read back: mean as sum times reciprocal
  assign mean_src   = (rd_sel == RD_MEAN_I) ? sum_r[1] : sum_r[0];
  assign mean_prod  = PROD_W'(mean_src) * PROD_W'(RECIP);
  assign mean_value = mean_prod[SHIFT +: SAMPLE_BITS];

  always_comb begin
    unique case (rd_sel)
      RD_RAW_V:  rd_value = REPLY_W'(raw_r[0]);
      RD_RAW_I:  rd_value = REPLY_W'(raw_r[1]);
      RD_MEAN_V: rd_value = REPLY_W'(mean_value);
      RD_MEAN_I: rd_value = REPLY_W'(mean_value);
      default:   rd_value = '0;
    endcase
  end

endmodule

>>> design/dcam_reply.sv
// command unit: led mode state, reply build and registered output beat
// depends on dcam_pkg
`timescale 1ns / 1ps

module dcam_reply (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  dcam_pkg::cmd_beat_t          cmd_beat,
  output logic                         cmd_ready,
  output dcam_pkg::rd_sel_t            rd_sel,
  input  logic [dcam_pkg::REPLY_W-1:0] rd_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_len,
  output logic [7:0]                   out_first,
  output logic [7:0]                   out_second,
  output logic                         out_led,
  output logic                         out_crit
);
  import dcam_pkg::*;

  logic      s1_valid_r;
  cmd_beat_t s1_beat_r;
  logic      led_r;
  logic      crit_r;
  logic      out_valid_r;
  logic [1:0] out_len_r;
  logic [7:0] out_first_r;
  logic [7:0] out_second_r;
  logic      out_led_r;
  logic      out_crit_r;

  logic       adv;
  logic       led_nxt;
  logic       crit_nxt;
  logic [1:0] len_nxt;
  logic [7:0] first_nxt;
  logic [7:0] second_nxt;
  logic       is_read;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign cmd_ready = !s1_valid_r || adv;

  always_comb begin
    unique case (s1_beat_r.command)
      CMD_RAW_V:  rd_sel = RD_RAW_V;
      CMD_RAW_I:  rd_sel = RD_RAW_I;
      CMD_MEAN_V: rd_sel = RD_MEAN_V;
      CMD_MEAN_I: rd_sel = RD_MEAN_I;
      default:    rd_sel = RD_RAW_V;
    endcase
  end

  always_comb begin
    led_nxt    = led_r;
    crit_nxt   = crit_r;
    len_nxt    = LEN_NONE;
    first_nxt  = '0;
    second_nxt = '0;
    is_read    = 1'b0;
    unique case (s1_beat_r.command)
      CMD_LED: begin
        // unknown mode or missing data byte leaves everything as is
        if (s1_beat_r.has_data) begin
          if (s1_beat_r.data_byte == LED_ON) begin
            led_nxt  = 1'b1;
            crit_nxt = 1'b0;
          end else if (s1_beat_r.data_byte == LED_OFF) begin
            led_nxt  = 1'b0;
            crit_nxt = 1'b0;
          end else if (s1_beat_r.data_byte == LED_CRIT) begin
            crit_nxt = 1'b1;
          end
        end
      end
      CMD_RAW_V, CMD_RAW_I, CMD_MEAN_V, CMD_MEAN_I: begin
        is_read = 1'b1;
      end
      CMD_DEVID: begin
        len_nxt   = LEN_ONE;
        first_nxt = DEVICE_ID;
      end
      default: begin
        len_nxt = LEN_NONE;
      end
    endcase
    if (is_read) begin
      len_nxt    = LEN_TWO;
      first_nxt  = rd_value[15:8];
      second_nxt = rd_value[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      led_r       <= 1'b0;
      crit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_ready) begin
        s1_valid_r <= cmd_valid;
      end
      if (adv) begin
        led_r       <= led_nxt;
        crit_r      <= crit_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      s1_beat_r <= cmd_beat;
    end
    if (adv) begin
      out_len_r    <= len_nxt;
      out_first_r  <= first_nxt;
      out_second_r <= second_nxt;
      out_led_r    <= led_nxt;
      out_crit_r   <= crit_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_len    = out_len_r;
  assign out_first  = out_first_r;
  assign out_second = out_second_r;
  assign out_led    = out_led_r;
  assign out_crit   = out_crit_r;

endmodule

>>> design/dual_channel_averaging_monitor_top.sv
// top level of the dual channel averaging monitor
// depends on dcam_pkg, dcam_chan, dcam_ram and dcam_reply
`timescale 1ns / 1ps

// Battery monitor with a voltage and a current channel and a small bus command
// set. Input beats carry an action on in_tuser: a voltage sample, a current
// sample or a bus command. A sample beat stores the raw reading and pushes it
// into that channel's ring of AVG_DEPTH entries; the first sample of a channel
// stands for the whole ring. A command beat either sets the led mode or asks
// for a reply (raw or mean value high byte first, or the device id) and always
// yields exactly one output beat; sample beats yield none. One beat is taken
// every cycle while in_tready is high: the ring lives in one ram with a
// registered read, read in the cycle a sample is accepted and written back the
// next, so consecutive samples touch different entries and the running sum is
// ready for the next sample. A command's reply goes via the command and output
// registers and reflects all samples accepted before it. The mean is the
// running sum times a reciprocal of AVG_DEPTH, exact over the whole sum range.
// No clearing pass is needed after reset. in_tready only drops while a reply
// waits on out_tready and a further command is already queued behind it.

module dual_channel_averaging_monitor_top #(
  parameter int AVG_DEPTH   = 8,
  parameter int SAMPLE_BITS = 10,
  localparam int IN_DATA_W  = ((SAMPLE_BITS + 17 + 7) / 8) * 8,
  localparam int OUT_DATA_W = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample, command, has_data, data_byte, zero padding
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // reply_length, reply_first, reply_second, led_lit, critical_mode, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata
);
  import dcam_pkg::*;

  localparam int CMD_LSB = SAMPLE_BITS;
  localparam int PAD_W   = OUT_DATA_W - 20;

  logic                   in_beat;
  logic                   smp_valid;
  logic                   cmd_valid;
  logic [SAMPLE_BITS-1:0] smp_value;
  cmd_beat_t              cmd_beat;
  rd_sel_t                rd_sel;
  logic [REPLY_W-1:0]     rd_value;

  logic [1:0] out_len;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic       out_led;
  logic       out_crit;

  // unused action code is swallowed with no effect
  assign in_beat   = in_tvalid && in_tready;
  assign smp_valid = in_beat && (in_tuser == ACT_VOLT || in_tuser == ACT_CURR);
  assign cmd_valid = in_tvalid && (in_tuser == ACT_CMD);

  assign smp_value          = in_tdata[SAMPLE_BITS-1:0];
  assign cmd_beat.command   = in_tdata[CMD_LSB +: 8];
  assign cmd_beat.has_data  = in_tdata[CMD_LSB + 8];
  assign cmd_beat.data_byte = in_tdata[CMD_LSB + 9 +: 8];

  dcam_chan #(
    .AVG_DEPTH  (AVG_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_chan (
    .clk      (clk),
    .rst_n    (rst_n),
    .smp_valid(smp_valid),
    .smp_ch   (in_tuser[0]),
    .smp_value(smp_value),
    .rd_sel   (rd_sel),
    .rd_value (rd_value)
  );

  dcam_reply u_reply (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_beat  (cmd_beat),
    .cmd_ready (in_tready),
    .rd_sel    (rd_sel),
    .rd_value  (rd_value),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_len   (out_len),
    .out_first (out_first),
    .out_second(out_second),
    .out_led   (out_led),
    .out_crit  (out_crit)
  );

  assign out_tdata = {{PAD_W{1'b0}}, out_crit, out_led, out_second, out_first, out_len};

endmodule

>>> tb/sv/tb_dual_channel_averaging_monitor_top.sv
// self-checking testbench for dual_channel_averaging_monitor_top
// depends on dcam_pkg and the top level; runs directed rows, then random beats
`timescale 1ns / 1ps

module tb_dual_channel_averaging_monitor_top;
  import dcam_pkg::*;

  localparam int AVG       = 8;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 24;
  localparam int RAND_BEATS = 850;
  localparam int CYCLE_CAP = 200000;
  localparam int HOLD_CYCLES = 160;

  // action code the block ignores
  localparam logic [1:0] ACT_NONE = 2'd3;
  // command codes outside the supported set
  localparam logic [7:0] CMD_BAD_HI  = 8'hFF;
  localparam logic [7:0] CMD_BAD_LOW = 8'h05;
  // led data bytes that are not a mode
  localparam logic [7:0] LED_BAD     = 8'h03;
  localparam logic [7:0] LED_BAD_HI  = 8'hFF;

  // one reply beat, as the checker sees it
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] first;
    logic [7:0] second;
    logic       led;
    logic       crit;
  } reply_t;

  // directed stimulus row; want is used only where typed is set
  typedef struct packed {
    logic [1:0] act;
    logic [9:0] smp;
    logic [7:0] cmd;
    logic       has;
    logic [7:0] dat;
    logic       typed;
    reply_t     want;
  } dir_row_t;

  localparam int NROWS = 24;
  localparam dir_row_t DIRECTED [NROWS] = '{
    // reads before any sample come back as zero
    '{ACT_CMD, 10'h000, CMD_RAW_V, 1'b0, 8'h00, 1'b1,
      '{LEN_TWO, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{ACT_CMD, 10'h000, CMD_MEAN_I, 1'b1, 8'hFF, 1'b1,
      '{LEN_TWO, 8'h00, 8'h00, 1'b0, 1'b0}},
    // device id: one byte, second byte zero
    '{ACT_CMD, 10'h000, CMD_DEVID, 1'b0, 8'h00, 1'b1,
      '{LEN_ONE, DEVICE_ID, 8'h00, 1'b0, 1'b0}},
    // unknown command, all other bits high
    '{ACT_CMD, 10'h3FF, CMD_BAD_HI, 1'b1, 8'hFF, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b0, 1'b0}},
    // led command without a data byte changes nothing
    '{ACT_CMD, 10'h000, CMD_LED, 1'b0, LED_ON, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{ACT_CMD, 10'h000, CMD_LED, 1'b1, LED_ON, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b1, 1'b0}},
    // critical keeps the led lit
    '{ACT_CMD, 10'h000, CMD_LED, 1'b1, LED_CRIT, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b1, 1'b1}},
    // bad mode byte leaves led and critical alone
    '{ACT_CMD, 10'h000, CMD_LED, 1'b1, LED_BAD, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b1, 1'b1}},
    '{ACT_CMD, 10'h000, CMD_LED, 1'b1, LED_OFF, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b0, 1'b0}},
    // critical while dark
    '{ACT_CMD, 10'h000, CMD_LED, 1'b1, LED_CRIT, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b0, 1'b1}},
    // unused action: no reply, no state change
    '{ACT_NONE, 10'h3FF, CMD_DEVID, 1'b1, 8'hFF, 1'b0, '0},
    // first voltage sample fills the ring with full scale
    '{ACT_VOLT, 10'h3FF, 8'h00, 1'b0, 8'h00, 1'b0, '0},
    '{ACT_CMD, 10'h000, CMD_RAW_V, 1'b0, 8'h00, 1'b1,
      '{LEN_TWO, 8'h03, 8'hFF, 1'b0, 1'b1}},
    '{ACT_CMD, 10'h000, CMD_MEAN_V, 1'b0, 8'h00, 1'b1,
      '{LEN_TWO, 8'h03, 8'hFF, 1'b0, 1'b1}},
    // current channel primed at zero, then full scale pushed in
    '{ACT_CURR, 10'h000, 8'hFF, 1'b1, 8'hFF, 1'b0, '0},
    '{ACT_CURR, 10'h3FF, 8'h00, 1'b0, 8'h00, 1'b0, '0},
    '{ACT_CMD, 10'h000, CMD_MEAN_I, 1'b0, 8'h00, 1'b0, '0},
    '{ACT_CMD, 10'h000, CMD_RAW_I, 1'b0, 8'h00, 1'b1,
      '{LEN_TWO, 8'h03, 8'hFF, 1'b0, 1'b1}},
    '{ACT_VOLT, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0, '0},
    '{ACT_CMD, 10'h000, CMD_MEAN_V, 1'b0, 8'h00, 1'b0, '0},
    '{ACT_CMD, 10'h000, CMD_DEVID, 1'b1, 8'h00, 1'b1,
      '{LEN_ONE, DEVICE_ID, 8'h00, 1'b0, 1'b1}},
    '{ACT_CMD, 10'h000, CMD_BAD_LOW, 1'b1, LED_ON, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b0, 1'b1}},
    '{ACT_CMD, 10'h000, CMD_LED, 1'b1, LED_BAD_HI, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b0, 1'b1}},
    // on clears critical
    '{ACT_CMD, 10'h000, CMD_LED, 1'b1, LED_ON, 1'b1,
      '{LEN_NONE, 8'h00, 8'h00, 1'b1, 1'b0}}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [1:0]       in_tuser = ACT_NONE;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // predictor state: rings, write positions, running sums, raw and mean per channel
  logic [9:0]  ring_m   [2][AVG];
  logic [2:0]  pos_m    [2];
  logic [12:0] sum_m    [2];
  logic [9:0]  raw_m    [2];
  logic [9:0]  mean_m   [2];
  bit          primed_m [2];
  bit          led_m;
  bit          crit_m;

  reply_t replies_due [$];
  int     errors = 0;
  int     cycle_count = 0;
  bit     quiet = 1'b0;      // no idling on either side
  bit     hold_req = 1'b0;   // ask the receiver for its long hold-off
  bit     hold_done = 1'b0;

  dual_channel_averaging_monitor_top #(
    .AVG_DEPTH  (AVG),
    .SAMPLE_BITS(10)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // advance the monitor model by one accepted beat; returns 1 when a reply is due
  function automatic bit predict_reply(input logic [1:0] act, input logic [9:0] smp,
                                       input logic [7:0] cmd, input logic has,
                                       input logic [7:0] dat, output reply_t rep);
    logic [9:0] readback;
    bit         ch;
    bit         is_read;
    int         k;
    rep = '0;
    readback = '0;
    is_read = 1'b0;
    if (act == ACT_VOLT || act == ACT_CURR) begin
      ch = act[0];
      raw_m[ch] = smp;
      if (!primed_m[ch]) begin
        // first sample stands for the whole ring
        for (k = 0; k < AVG; k++) ring_m[ch][k] = smp;
        sum_m[ch] = 13'(smp) * 13'(AVG);
        pos_m[ch] = 3'(1 % AVG);
        mean_m[ch] = smp;
        primed_m[ch] = 1'b1;
      end else begin
        sum_m[ch] = sum_m[ch] - 13'(ring_m[ch][pos_m[ch]]) + 13'(smp);
        ring_m[ch][pos_m[ch]] = smp;
        pos_m[ch] = (int'(pos_m[ch]) == AVG - 1) ? 3'd0 : pos_m[ch] + 3'd1;
        mean_m[ch] = 10'(sum_m[ch] / 13'(AVG));
      end
      return 1'b0;
    end
    if (act != ACT_CMD) return 1'b0;
    case (cmd)
      CMD_LED: begin
        if (has && dat == LED_ON) begin
          led_m = 1'b1;
          crit_m = 1'b0;
        end else if (has && dat == LED_OFF) begin
          led_m = 1'b0;
          crit_m = 1'b0;
        end else if (has && dat == LED_CRIT) begin
          crit_m = 1'b1;
        end
      end
      CMD_RAW_V: begin
        readback = raw_m[0];
        is_read = 1'b1;
      end
      CMD_RAW_I: begin
        readback = raw_m[1];
        is_read = 1'b1;
      end
      CMD_MEAN_V: begin
        readback = mean_m[0];
        is_read = 1'b1;
      end
      CMD_MEAN_I: begin
        readback = mean_m[1];
        is_read = 1'b1;
      end
      CMD_DEVID: begin
        rep.len = LEN_ONE;
        rep.first = DEVICE_ID;
      end
      default: ;
    endcase
    if (is_read) begin
      rep.len = LEN_TWO;
      rep.first = {6'b0, readback[9:8]};
      rep.second = readback[7:0];
    end
    rep.led = led_m;
    rep.crit = crit_m;
    return 1'b1;
  endfunction

  // offer one beat and hold it until the handshake; want overrides the prediction when use_want is set
  task automatic drive_beat(input logic [1:0] act, input logic [9:0] smp,
                            input logic [7:0] cmd, input logic has, input logic [7:0] dat,
                            input bit use_want, input reply_t want);
    reply_t rep;
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {5'b0, dat, has, cmd, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_reply(act, smp, cmd, has, dat, rep))
      replies_due.push_back(use_want ? want : rep);
  endtask

  // random sender gap, skipped while quiet or while the receiver holds off
  task automatic maybe_idle();
    if (!quiet && !(hold_req && !hold_done) && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // reply checker: every accepted output beat against the oldest expectation
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[1:0], out_tdata[9:2], out_tdata[17:10], out_tdata[18], out_tdata[19]};
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = replies_due.pop_front();
        check_field("reply_length", want.len, got.len);
        check_field("reply_first", want.first, got.first);
        check_field("reply_second", want.second, got.second);
        check_field("led_lit", want.led, got.led);
        check_field("critical_mode", want.crit, got.crit);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("%0t: timeout with %0d replies outstanding", $time, replies_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: ready stretches, random stall bursts, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int         i;
    int         pick;
    logic [1:0] act;
    logic [9:0] smp;
    logic [7:0] cmd;
    logic       has;
    logic [7:0] dat;
    led_m = 1'b0;
    crit_m = 1'b0;
    for (i = 0; i < 2; i++) begin
      pos_m[i] = '0;
      sum_m[i] = '0;
      raw_m[i] = '0;
      mean_m[i] = '0;
      primed_m[i] = 1'b0;
      for (int k = 0; k < AVG; k++) ring_m[i][k] = '0;
    end

    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: extremes, every command, led modes, ignored action
    for (i = 0; i < NROWS; i++) begin
      maybe_idle();
      drive_beat(DIRECTED[i].act, DIRECTED[i].smp, DIRECTED[i].cmd, DIRECTED[i].has,
                 DIRECTED[i].dat, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random part: mostly samples and well-formed commands, some noise
    for (i = 0; i < RAND_BEATS; i++) begin
      if (i == 300) hold_req = 1'b1;
      quiet = (i >= RAND_BEATS - 90);
      maybe_idle();
      // unused fields carry random bits too
      smp = 10'($urandom_range(0, 1023));
      cmd = 8'($urandom_range(0, 255));
      has = 1'($urandom_range(0, 1));
      dat = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        act = $urandom_range(0, 1) ? ACT_CURR : ACT_VOLT;
        case ($urandom_range(0, 9))
          0: smp = 10'h000;
          1: smp = 10'h3FF;
          default: ;
        endcase
      end else if (pick < 90) begin
        act = ACT_CMD;
        case ($urandom_range(0, 6))
          0: cmd = CMD_RAW_V;
          1: cmd = CMD_RAW_I;
          2: cmd = CMD_MEAN_V;
          3: cmd = CMD_MEAN_I;
          4: cmd = CMD_DEVID;
          default: begin
            cmd = CMD_LED;
            has = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 3))
              0: dat = LED_OFF;
              1: dat = LED_ON;
              2: dat = LED_CRIT;
              default: ;
            endcase
          end
        endcase
      end else if (pick < 97) begin
        act = ACT_CMD;
      end else begin
        act = ACT_NONE;
      end
      drive_beat(act, smp, cmd, has, dat, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // drain, then let the pipeline settle in case a stray beat follows
    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/dcam_pkg.sv
design/dcam_ram.sv
design/dcam_chan.sv
design/dcam_reply.sv
design/dual_channel_averaging_monitor_top.sv
tb/sv/tb_dual_channel_averaging_monitor_top.sv
